FILE: rtl/vertex_diffuse_lighting_unit_assert.svh
// ----------------------------------------------------------------------------
// Vertex diffuse lighting assertion macros
// Shared property forms for the lighting unit checkers.
// ----------------------------------------------------------------------------
`ifndef VERTEX_DIFFUSE_LIGHTING_UNIT_ASSERT_SVH
`define VERTEX_DIFFUSE_LIGHTING_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VDL_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define VDL_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/vdl_pkg.sv
// ----------------------------------------------------------------------------
// Vertex diffuse lighting package
// Field widths, register indexes, request codes and the table write bundle.
// ----------------------------------------------------------------------------
package vdl_pkg;

  localparam int COORD_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int LIDX_W     = 3;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_BLUE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_COUNT   = 2'd3;

  localparam logic REQ_LIGHT = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic                      en;
    logic [LIDX_W-1:0]         index;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
  } light_wr_t;

endpackage

FILE: rtl/vdl_if.sv
// ----------------------------------------------------------------------------
// Vertex diffuse lighting channels
// Valid/ready request and result channels of the lighting unit.
// ----------------------------------------------------------------------------
interface vdl_req_if import vdl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [COORD_W-1:0] normal_x;
  logic signed [COORD_W-1:0] normal_y;
  logic signed [COORD_W-1:0] normal_z;
  logic [LIDX_W-1:0]         light_index;
  logic signed [COORD_W-1:0] light_dir_x;
  logic signed [COORD_W-1:0] light_dir_y;
  logic signed [COORD_W-1:0] light_dir_z;
  logic [COLOR_W-1:0]        light_red;
  logic [COLOR_W-1:0]        light_green;
  logic [COLOR_W-1:0]        light_blue;

  modport source (output valid, req_type, normal_x, normal_y, normal_z, light_index,
                  light_dir_x, light_dir_y, light_dir_z, light_red, light_green,
                  light_blue, input ready);
  modport sink (input valid, req_type, normal_x, normal_y, normal_z, light_index,
                light_dir_x, light_dir_y, light_dir_z, light_red, light_green,
                light_blue, output ready);
endinterface

interface vdl_res_if import vdl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] lit_red;
  logic [COLOR_W-1:0] lit_green;
  logic [COLOR_W-1:0] lit_blue;

  modport source (output valid, lit_red, lit_green, lit_blue, input ready);
  modport sink (input valid, lit_red, lit_green, lit_blue, output ready);
endinterface

FILE: rtl/vdl_norm.sv
// ----------------------------------------------------------------------------
// Vertex diffuse lighting normalizer
// Squares, bit-serial division and bit-pair square root for three components.
// ----------------------------------------------------------------------------
module vdl_norm import vdl_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] vec_x,
  input  logic signed [COORD_W-1:0] vec_y,
  input  logic signed [COORD_W-1:0] vec_z,
  output logic                      done,
  output logic signed [FRAC_BITS+1:0] norm_x,
  output logic signed [FRAC_BITS+1:0] norm_y,
  output logic signed [FRAC_BITS+1:0] norm_z
);

  localparam int SQ_W  = 2 * COORD_W;
  localparam int RW    = SQ_W + 1;
  localparam int QW    = 2 * FRAC_BITS + 1;
  localparam int RQ    = 2 * FRAC_BITS + 2;
  localparam int RES_W = FRAC_BITS + 1;
  localparam int RR_W  = FRAC_BITS + 3;
  localparam int CUR_W = FRAC_BITS + 5;
  localparam int NW    = FRAC_BITS + 2;
  localparam int CNTW  = $clog2(2 * FRAC_BITS);

  typedef enum logic [6:0] {
    N_IDLE = 7'b0000001,
    N_SQ   = 7'b0000010,
    N_SUM  = 7'b0000100,
    N_LOAD = 7'b0001000,
    N_DIV  = 7'b0010000,
    N_ROOT = 7'b0100000,
    N_DONE = 7'b1000000
  } phase_t;

  phase_t phase;
  logic [CNTW-1:0] cnt;
  logic signed [COORD_W-1:0] vin [3];
  logic [COORD_W-1:0] mag [3];
  logic neg [3];
  logic [SQ_W-1:0] sq [3];
  logic [SQ_W-1:0] s;
  logic zero;
  logic [RW-1:0] rem [3];
  logic [QW-1:0] q [3];
  logic [RQ-1:0] rq [3];
  logic [RES_W-1:0] res [3];
  logic [RR_W-1:0] rrem [3];
  logic [RW-1:0] rem_next [3];
  logic [QW-1:0] q_next [3];
  logic [RES_W-1:0] res_next [3];
  logic [RR_W-1:0] rrem_next [3];
  logic signed [NW-1:0] nout [3];

  assign vin[0] = vec_x;
  assign vin[1] = vec_y;
  assign vin[2] = vec_z;

  always_comb begin
    logic [RW-1:0] sh;
    logic [CUR_W-1:0] cur;
    logic [CUR_W-1:0] trial;
    for (int c = 0; c < 3; c++) begin
      sh = {rem[c][RW-2:0], 1'b0};
      if (sh >= RW'(s)) begin
        rem_next[c] = sh - RW'(s);
        q_next[c] = {q[c][QW-2:0], 1'b1};
      end else begin
        rem_next[c] = sh;
        q_next[c] = {q[c][QW-2:0], 1'b0};
      end
      cur = {rrem[c], rq[c][RQ-1:RQ-2]};
      trial = {2'b00, res[c], 2'b01};
      if (cur >= trial) begin
        rrem_next[c] = RR_W'(cur - trial);
        res_next[c] = {res[c][RES_W-2:0], 1'b1};
      end else begin
        rrem_next[c] = cur[RR_W-1:0];
        res_next[c] = {res[c][RES_W-2:0], 1'b0};
      end
      if (zero) begin
        nout[c] = '0;
      end else if (neg[c]) begin
        nout[c] = -$signed(NW'(res[c]));
      end else begin
        nout[c] = $signed(NW'(res[c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= N_IDLE;
      cnt <= '0;
    end else begin
      unique case (phase)
        N_IDLE: if (start) phase <= N_SQ;
        N_SQ:   phase <= N_SUM;
        N_SUM:  phase <= N_LOAD;
        N_LOAD: begin
          phase <= N_DIV;
          cnt <= CNTW'(2 * FRAC_BITS - 1);
        end
        N_DIV: begin
          if (cnt == '0) begin
            phase <= N_ROOT;
            cnt <= CNTW'(FRAC_BITS);
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        N_ROOT: begin
          if (cnt == '0) begin
            phase <= N_DONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        N_DONE: phase <= N_IDLE;
        default: phase <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (phase == N_IDLE && start) begin
        neg[c] <= vin[c][COORD_W-1];
        mag[c] <= vin[c][COORD_W-1] ? (~vin[c] + 1'b1) : vin[c];
      end
      if (phase == N_SQ) begin
        sq[c] <= mag[c] * mag[c];
      end
      if (phase == N_LOAD) begin
        if (sq[c] >= s) begin
          q[c] <= QW'(1);
          rem[c] <= RW'(sq[c] - s);
        end else begin
          q[c] <= '0;
          rem[c] <= RW'(sq[c]);
        end
      end
      if (phase == N_DIV) begin
        rem[c] <= rem_next[c];
        q[c] <= q_next[c];
        if (cnt == '0) begin
          rq[c] <= {1'b0, q_next[c]};
          res[c] <= '0;
          rrem[c] <= '0;
        end
      end
      if (phase == N_ROOT) begin
        rq[c] <= {rq[c][RQ-3:0], 2'b00};
        res[c] <= res_next[c];
        rrem[c] <= rrem_next[c];
      end
    end
    if (phase == N_SUM) begin
      s <= sq[0] + sq[1] + sq[2];
      zero <= (sq[0] == '0) && (sq[1] == '0) && (sq[2] == '0);
    end
  end

  assign done = (phase == N_DONE);
  assign norm_x = nout[0];
  assign norm_y = nout[1];
  assign norm_z = nout[2];

endmodule

FILE: rtl/vdl_light_cell.sv
// ----------------------------------------------------------------------------
// Vertex diffuse lighting cell
// Holds one light entry and adds its diffuse term to the passing colour.
// ----------------------------------------------------------------------------
module vdl_light_cell import vdl_pkg::*; #(
  parameter int IDX   = 0,
  parameter int NW    = 16,
  parameter int ACC_W = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [CNT_W-1:0]        light_count,
  input  light_wr_t               wr,
  input  logic                    prev_valid,
  input  logic [ACC_W-1:0]        prev_acc_r,
  input  logic [ACC_W-1:0]        prev_acc_g,
  input  logic [ACC_W-1:0]        prev_acc_b,
  input  logic signed [NW-1:0]    prev_nx,
  input  logic signed [NW-1:0]    prev_ny,
  input  logic signed [NW-1:0]    prev_nz,
  output logic                    next_valid,
  output logic [ACC_W-1:0]        next_acc_r,
  output logic [ACC_W-1:0]        next_acc_g,
  output logic [ACC_W-1:0]        next_acc_b,
  output logic signed [NW-1:0]    next_nx,
  output logic signed [NW-1:0]    next_ny,
  output logic signed [NW-1:0]    next_nz
);

  localparam int PW = NW + COORD_W;
  localparam int DW = PW + 2;
  localparam int CW = DW - 1;

  logic signed [COORD_W-1:0] dir_x, dir_y, dir_z;
  logic [COLOR_W-1:0] red, green, blue;
  logic signed [PW-1:0] px, py, pz;
  logic signed [DW-1:0] dot;
  logic s1_valid;
  logic [ACC_W-1:0] s1_acc_r, s1_acc_g, s1_acc_b;
  logic signed [NW-1:0] s1_nx, s1_ny, s1_nz;
  logic active;
  logic [CW-1:0] cosv;
  logic [CW+COLOR_W-1:0] pr, pg, pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_x <= '0;
      dir_y <= '0;
      dir_z <= '0;
      red <= '0;
      green <= '0;
      blue <= '0;
    end else if (wr.en && ({1'b0, wr.index} == (LIDX_W + 1)'(IDX))) begin
      dir_x <= wr.dir_x;
      dir_y <= wr.dir_y;
      dir_z <= wr.dir_z;
      red <= wr.red;
      green <= wr.green;
      blue <= wr.blue;
    end
  end

  assign px = prev_nx * dir_x;
  assign py = prev_ny * dir_y;
  assign pz = prev_nz * dir_z;
  assign active = ({1'b0, light_count} > (CNT_W + 1)'(IDX));
  assign cosv = dot[CW-1:0];
  assign pr = red * cosv;
  assign pg = green * cosv;
  assign pb = blue * cosv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      next_valid <= 1'b0;
    end else begin
      s1_valid <= prev_valid;
      next_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    dot <= DW'(px) + DW'(py) + DW'(pz);
    s1_acc_r <= prev_acc_r;
    s1_acc_g <= prev_acc_g;
    s1_acc_b <= prev_acc_b;
    s1_nx <= prev_nx;
    s1_ny <= prev_ny;
    s1_nz <= prev_nz;
    next_nx <= s1_nx;
    next_ny <= s1_ny;
    next_nz <= s1_nz;
    if (active && !dot[DW-1] && (dot != '0)) begin
      next_acc_r <= s1_acc_r + ACC_W'(pr);
      next_acc_g <= s1_acc_g + ACC_W'(pg);
      next_acc_b <= s1_acc_b + ACC_W'(pb);
    end else begin
      next_acc_r <= s1_acc_r;
      next_acc_g <= s1_acc_g;
      next_acc_b <= s1_acc_b;
    end
  end

endmodule

FILE: rtl/vertex_diffuse_lighting_unit.sv
// A light request passes through the divide and square root loops of the
// normalizer and then the registered cells of the light chain before its result
// is offered; a write request is written into the light table when accepted.
// No new request is taken until a light request's result has been taken.
// Reset is synchronous: registers return to ambient 255 and no lights, the table
// clears and both channels go idle.
// ----------------------------------------------------------------------------
// Vertex diffuse lighting unit
// Ambient plus Lambert diffuse lighting of one vertex normal per request.
// ----------------------------------------------------------------------------
module vertex_diffuse_lighting_unit import vdl_pkg::*; #(
  parameter int MAX_LIGHTS = 8,
  parameter int FRAC_BITS  = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  vdl_req_if.sink               req_ch,
  vdl_res_if.source             res_ch
);

  localparam int NW    = FRAC_BITS + 2;
  localparam int ACC_A = 2 * FRAC_BITS + COLOR_W + 1;
  localparam int ACC_B = FRAC_BITS + 31;
  localparam int ACC_W = (ACC_A > ACC_B ? ACC_A : ACC_B) + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_NORM  = 4'b0010,
    S_CHAIN = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state;
  logic [COLOR_W-1:0] ambient_red, ambient_green, ambient_blue;
  logic [CNT_W-1:0] light_count;
  logic accept;
  light_wr_t wr;
  logic norm_done;
  logic signed [NW-1:0] norm_x, norm_y, norm_z;
  logic chain_valid [MAX_LIGHTS+1];
  logic [ACC_W-1:0] chain_r [MAX_LIGHTS+1];
  logic [ACC_W-1:0] chain_g [MAX_LIGHTS+1];
  logic [ACC_W-1:0] chain_b [MAX_LIGHTS+1];
  logic signed [NW-1:0] chain_x [MAX_LIGHTS+1];
  logic signed [NW-1:0] chain_y [MAX_LIGHTS+1];
  logic signed [NW-1:0] chain_z [MAX_LIGHTS+1];
  logic [COLOR_W-1:0] lit_red, lit_green, lit_blue;

  function automatic logic [COLOR_W-1:0] saturate(input logic [ACC_W-1:0] acc);
    if (acc > (ACC_W'(255) << (2 * FRAC_BITS))) begin
      return 8'd255;
    end
    return acc[2*FRAC_BITS +: COLOR_W];
  endfunction

  assign req_ch.ready = (state == S_IDLE);
  assign accept = req_ch.valid && req_ch.ready;

  assign wr.en = accept && (req_ch.req_type == REQ_WRITE);
  assign wr.index = req_ch.light_index;
  assign wr.dir_x = req_ch.light_dir_x;
  assign wr.dir_y = req_ch.light_dir_y;
  assign wr.dir_z = req_ch.light_dir_z;
  assign wr.red = req_ch.light_red;
  assign wr.green = req_ch.light_green;
  assign wr.blue = req_ch.light_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      ambient_red <= 8'd255;
      ambient_green <= 8'd255;
      ambient_blue <= 8'd255;
      light_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AMBIENT_RED:   ambient_red <= cfg_wdata;
        CFG_AMBIENT_GREEN: ambient_green <= cfg_wdata;
        CFG_AMBIENT_BLUE:  ambient_blue <= cfg_wdata;
        CFG_LIGHT_COUNT:   light_count <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  vdl_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && (req_ch.req_type == REQ_LIGHT)),
    .vec_x  (req_ch.normal_x),
    .vec_y  (req_ch.normal_y),
    .vec_z  (req_ch.normal_z),
    .done   (norm_done),
    .norm_x (norm_x),
    .norm_y (norm_y),
    .norm_z (norm_z)
  );

  assign chain_valid[0] = norm_done && (state == S_NORM);
  assign chain_r[0] = ACC_W'(ambient_red) << (2 * FRAC_BITS);
  assign chain_g[0] = ACC_W'(ambient_green) << (2 * FRAC_BITS);
  assign chain_b[0] = ACC_W'(ambient_blue) << (2 * FRAC_BITS);
  assign chain_x[0] = norm_x;
  assign chain_y[0] = norm_y;
  assign chain_z[0] = norm_z;

  for (genvar i = 0; i < MAX_LIGHTS; i++) begin : g_cell
    vdl_light_cell #(.IDX(i), .NW(NW), .ACC_W(ACC_W)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .light_count (light_count),
      .wr          (wr),
      .prev_valid  (chain_valid[i]),
      .prev_acc_r  (chain_r[i]),
      .prev_acc_g  (chain_g[i]),
      .prev_acc_b  (chain_b[i]),
      .prev_nx     (chain_x[i]),
      .prev_ny     (chain_y[i]),
      .prev_nz     (chain_z[i]),
      .next_valid  (chain_valid[i+1]),
      .next_acc_r  (chain_r[i+1]),
      .next_acc_g  (chain_g[i+1]),
      .next_acc_b  (chain_b[i+1]),
      .next_nx     (chain_x[i+1]),
      .next_ny     (chain_y[i+1]),
      .next_nz     (chain_z[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (accept && (req_ch.req_type == REQ_LIGHT)) state <= S_NORM;
        S_NORM:  if (norm_done) state <= S_CHAIN;
        S_CHAIN: if (chain_valid[MAX_LIGHTS]) state <= S_OUT;
        S_OUT:   if (res_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CHAIN && chain_valid[MAX_LIGHTS]) begin
      lit_red <= saturate(chain_r[MAX_LIGHTS]);
      lit_green <= saturate(chain_g[MAX_LIGHTS]);
      lit_blue <= saturate(chain_b[MAX_LIGHTS]);
    end
  end

  assign res_ch.valid = (state == S_OUT);
  assign res_ch.lit_red = lit_red;
  assign res_ch.lit_green = lit_green;
  assign res_ch.lit_blue = lit_blue;

endmodule

FILE: rtl/vdl_checker.sv
// ----------------------------------------------------------------------------
// Vertex diffuse lighting checker
// Port-level checks of the lighting unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "vertex_diffuse_lighting_unit_assert.svh"

module vdl_checker import vdl_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [COLOR_W-1:0] lit_red,
  input logic [COLOR_W-1:0] lit_green,
  input logic [COLOR_W-1:0] lit_blue
);

  `VDL_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid, "result dropped")
  `VDL_ASSERT_NEXT(a_res_stable, clk, rst, res_valid && !res_ready, $stable(lit_red) && $stable(lit_green) && $stable(lit_blue), "result changed while stalled")
  `VDL_ASSERT_NOW(a_one_side, clk, rst, res_valid, !req_ready, "request taken while result pending")
  `VDL_ASSERT_NEXT(a_no_early, clk, rst, req_valid && req_ready, !res_valid, "result too soon after request")
  `VDL_ASSERT_NEXT(a_single, clk, rst, res_valid && res_ready, !res_valid, "result repeated")

endmodule

bind vertex_diffuse_lighting_unit vdl_checker u_vdl_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_ch.valid),
  .req_ready (req_ch.ready),
  .res_valid (res_ch.valid),
  .res_ready (res_ch.ready),
  .lit_red   (res_ch.lit_red),
  .lit_green (res_ch.lit_green),
  .lit_blue  (res_ch.lit_blue)
);
